### rtl/core/bti_pkg.sv
package bti_pkg;

  // geometry
  localparam int unsigned SEGMENT_COUNT = 5;
  localparam int unsigned SEG_IDX_W     = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam int unsigned TEMP_W        = 16;
  localparam int unsigned DUTY_W        = 4;
  localparam int unsigned SEG_W         = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned IN_DATA_W     = 112;
  localparam int unsigned OUT_DATA_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIE_DISABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIE_ENABLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONBOARD_DISABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONBOARD_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTOR_DISABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTOR_ENABLE  = 3'd5;

  // reset thresholds, 1/16 C
  localparam logic signed [TEMP_W-1:0] DIE_DISABLE_RST      = 16'sd1360;
  localparam logic signed [TEMP_W-1:0] DIE_ENABLE_RST       = 16'sd1200;
  localparam logic signed [TEMP_W-1:0] ONBOARD_DISABLE_RST  = 16'sd1120;
  localparam logic signed [TEMP_W-1:0] ONBOARD_ENABLE_RST   = 16'sd960;
  localparam logic signed [TEMP_W-1:0] RESISTOR_DISABLE_RST = 16'sd1600;
  localparam logic signed [TEMP_W-1:0] RESISTOR_ENABLE_RST  = 16'sd1440;

  // item kinds
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_DUTY   = 1'b1
  } bti_cmd_e;

  // per-chip flags
  typedef struct packed {
    logic resistor_hot;
    logic onboard_hot;
    logic die_hot;
  } bti_flags_t;

  // threshold register set
  typedef struct packed {
    logic signed [TEMP_W-1:0] die_disable;
    logic signed [TEMP_W-1:0] die_enable;
    logic signed [TEMP_W-1:0] onboard_disable;
    logic signed [TEMP_W-1:0] onboard_enable;
    logic signed [TEMP_W-1:0] resistor_disable;
    logic signed [TEMP_W-1:0] resistor_enable;
  } bti_thresh_t;

  // one result transaction
  typedef struct packed {
    logic [DUTY_W-1:0] granted_duty;
    logic              blocked_changed;
    logic              beta_blocked;
    logic              alpha_blocked;
    bti_flags_t        beta;
    bti_flags_t        alpha;
  } bti_result_t;

endpackage

### rtl/core/bti_lane.sv
module bti_lane
  import bti_pkg::*;
(
  input  bti_thresh_t              thresh_i,
  input  bti_flags_t               flags_i,
  input  logic signed [TEMP_W-1:0] die_temp_i,
  input  logic signed [TEMP_W-1:0] chip_temp_i,
  input  logic signed [TEMP_W-1:0] bank_temp_i,
  output bti_flags_t               flags_o
);

  // active-high hysteresis: clear flag sets at disable, set flag clears at enable
  function automatic logic hyst(input logic signed [TEMP_W-1:0] t,
                                input logic signed [TEMP_W-1:0] dis,
                                input logic signed [TEMP_W-1:0] en,
                                input logic hot);
    logic res;
    res = hot;
    if (!hot && (t >= dis)) res = 1'b1;
    if (hot && (t <= en)) res = 1'b0;
    return res;
  endfunction

  // three independent flag comparators for one chip
  always_comb begin
    flags_o.die_hot      = hyst(die_temp_i, thresh_i.die_disable, thresh_i.die_enable,
                                flags_i.die_hot);
    flags_o.onboard_hot  = hyst(chip_temp_i, thresh_i.onboard_disable,
                                thresh_i.onboard_enable, flags_i.onboard_hot);
    flags_o.resistor_hot = hyst(bank_temp_i, thresh_i.resistor_disable,
                                thresh_i.resistor_enable, flags_i.resistor_hot);
  end

endmodule

### rtl/core/bti_merge.sv
module bti_merge
  import bti_pkg::*;
(
  input  bti_cmd_e          cmd_i,
  input  logic              seg_ok_i,
  input  logic              chip_side_i,
  input  logic [DUTY_W-1:0] requested_duty_i,
  input  bti_flags_t        alpha_old_i,
  input  bti_flags_t        beta_old_i,
  input  bti_flags_t        alpha_new_i,
  input  bti_flags_t        beta_new_i,
  output bti_result_t       result_o
);

  bti_flags_t a;
  bti_flags_t b;
  logic       a_blk;
  logic       b_blk;
  logic       sel_blk;

  // sample takes lane results, duty request shows stored flags
  assign a = (cmd_i == CMD_SAMPLE) ? alpha_new_i : alpha_old_i;
  assign b = (cmd_i == CMD_SAMPLE) ? beta_new_i  : beta_old_i;

  assign a_blk   = |a;
  assign b_blk   = |b;
  assign sel_blk = chip_side_i ? b_blk : a_blk;

  // combine both lanes into one result, all zero for a bad segment
  always_comb begin
    result_o = '0;
    if (seg_ok_i) begin
      result_o.alpha         = a;
      result_o.beta          = b;
      result_o.alpha_blocked = a_blk;
      result_o.beta_blocked  = b_blk;
      if (cmd_i == CMD_SAMPLE) begin
        result_o.blocked_changed = ((|alpha_old_i) != a_blk) || ((|beta_old_i) != b_blk);
      end else begin
        result_o.granted_duty = sel_blk ? '0 : requested_duty_i;
      end
    end
  end

endmodule

### rtl/core/balance_thermal_interlock_top.sv
// channel   | direction | handshake           | contents
// s_axis    | in        | tvalid/tready       | tuser: cmd; tdata: segment, six temps, side, duty
// m_axis    | out       | tvalid/tready       | tdata: six hot flags, blocked, changed, duty
// cfg       | in        | cfg_we_i            | cfg_idx_i selects threshold, cfg_data_i value
//
// one transaction per cycle unless both output stages hold results; results are registered
// flags of a segment are read, updated by the two chip lanes and written back in the
// accepting cycle, so consecutive transactions on one segment see each other's updates
// an output register plus a skid register decouple the sides; tready drops only when
// both hold results
// rst_ni clears all flags and both output valid bits, and sets thresholds to their defaults
module balance_thermal_interlock_top
  import bti_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] segment_index, [19:4] alpha_die_temp, [35:20] beta_die_temp,
  // [51:36] alpha chip thermistor, [67:52] beta chip thermistor, [83:68] alpha_bank_therm,
  // [99:84] beta_bank_therm, [100] chip_side, [104:101] requested_duty, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] alpha_die_hot, [1] alpha_onboard_hot, [2] alpha_resistor_hot, [3] beta_die_hot,
  // [4] beta_onboard_hot, [5] beta_resistor_hot, [6] alpha_blocked, [7] beta_blocked,
  // [8] blocked_changed, [12:9] granted_duty, [15:13] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TEMP_W-1:0]     cfg_data_i
);

  bti_thresh_t thresh_q;
  bti_flags_t  alpha_flags_q [SEGMENT_COUNT];
  bti_flags_t  beta_flags_q  [SEGMENT_COUNT];

  logic                     accept;
  bti_cmd_e                 cmd;
  logic [SEG_W-1:0]         seg;
  logic [SEG_IDX_W-1:0]     seg_idx;
  logic                     seg_ok;
  logic signed [TEMP_W-1:0] alpha_die, beta_die, alpha_ctherm, beta_ctherm;
  logic signed [TEMP_W-1:0] alpha_bank, beta_bank, chip_max;
  logic                     chip_side;
  logic [DUTY_W-1:0]        req_duty;
  bti_flags_t               alpha_old, beta_old, alpha_new, beta_new;
  bti_result_t              result;

  bti_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  // input field unpacking
  assign cmd          = bti_cmd_e'(s_axis_tuser);
  assign seg          = s_axis_tdata[3:0];
  assign alpha_die    = s_axis_tdata[19:4];
  assign beta_die     = s_axis_tdata[35:20];
  assign alpha_ctherm = s_axis_tdata[51:36];
  assign beta_ctherm  = s_axis_tdata[67:52];
  assign alpha_bank   = s_axis_tdata[83:68];
  assign beta_bank    = s_axis_tdata[99:84];
  assign chip_side    = s_axis_tdata[100];
  assign req_duty     = s_axis_tdata[104:101];

  assign seg_ok  = ({1'b0, seg} < (SEG_W + 1)'(SEGMENT_COUNT));
  assign seg_idx = seg[SEG_IDX_W-1:0];

  // segment flag read, zero for an out-of-range segment
  assign alpha_old = seg_ok ? alpha_flags_q[seg_idx] : '0;
  assign beta_old  = seg_ok ? beta_flags_q[seg_idx]  : '0;

  // shared chip thermistor value is the hotter of the two
  assign chip_max = (beta_ctherm > alpha_ctherm) ? beta_ctherm : alpha_ctherm;

  bti_lane u_lane_alpha (
    .thresh_i    (thresh_q),
    .flags_i     (alpha_old),
    .die_temp_i  (alpha_die),
    .chip_temp_i (chip_max),
    .bank_temp_i (alpha_bank),
    .flags_o     (alpha_new)
  );

  bti_lane u_lane_beta (
    .thresh_i    (thresh_q),
    .flags_i     (beta_old),
    .die_temp_i  (beta_die),
    .chip_temp_i (chip_max),
    .bank_temp_i (beta_bank),
    .flags_o     (beta_new)
  );

  bti_merge u_merge (
    .cmd_i            (cmd),
    .seg_ok_i         (seg_ok),
    .chip_side_i      (chip_side),
    .requested_duty_i (req_duty),
    .alpha_old_i      (alpha_old),
    .beta_old_i       (beta_old),
    .alpha_new_i      (alpha_new),
    .beta_new_i       (beta_new),
    .result_o         (result)
  );

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.die_disable      <= DIE_DISABLE_RST;
      thresh_q.die_enable       <= DIE_ENABLE_RST;
      thresh_q.onboard_disable  <= ONBOARD_DISABLE_RST;
      thresh_q.onboard_enable   <= ONBOARD_ENABLE_RST;
      thresh_q.resistor_disable <= RESISTOR_DISABLE_RST;
      thresh_q.resistor_enable  <= RESISTOR_ENABLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIE_DISABLE:      thresh_q.die_disable      <= cfg_data_i;
        REG_DIE_ENABLE:       thresh_q.die_enable       <= cfg_data_i;
        REG_ONBOARD_DISABLE:  thresh_q.onboard_disable  <= cfg_data_i;
        REG_ONBOARD_ENABLE:   thresh_q.onboard_enable   <= cfg_data_i;
        REG_RESISTOR_DISABLE: thresh_q.resistor_disable <= cfg_data_i;
        REG_RESISTOR_ENABLE:  thresh_q.resistor_enable  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flag write-back on an accepted sample transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEGMENT_COUNT; i++) begin
        alpha_flags_q[i] <= '0;
        beta_flags_q[i]  <= '0;
      end
    end else if (accept && seg_ok && (cmd == CMD_SAMPLE)) begin
      alpha_flags_q[seg_idx] <= alpha_new;
      beta_flags_q[seg_idx]  <= beta_new;
    end
  end

  // output register with skid stage
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(bti_result_t)){1'b0}}, out_q};

`ifndef ASSERT_OFF
  // skid stage only fills behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid with empty output register");

  // a result that grants duty came from a duty transaction
  a_duty_no_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.granted_duty != '0)) |-> !out_q.blocked_changed)
    else $error("duty granted on a sample result");

  // granted duty never goes out while both chips are shown blocked
  a_duty_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alpha_blocked && out_q.beta_blocked) |->
      (out_q.granted_duty == '0))
    else $error("duty granted to a blocked chip");

  // a held result is not lost while the sink stalls
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result dropped or changed");
`endif

endmodule

### tb/bti_interlock_monitor.sv
module bti_interlock_monitor
  import bti_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [TEMP_W-1:0]     cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of thresholds and per-chip flags
  bti_thresh_t limits;
  bti_flags_t  chip_flags [2*SEGMENT_COUNT];
  bti_result_t expected_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // hysteresis: clear flag sets at or above disable, set flag clears at or below enable
  function automatic logic next_hot(input logic hot, input logic signed [TEMP_W-1:0] t,
                                    input logic signed [TEMP_W-1:0] dis,
                                    input logic signed [TEMP_W-1:0] en);
    if (!hot && t >= dis) return 1'b1;
    if (hot && t <= en) return 1'b0;
    return hot;
  endfunction

  function automatic bti_flags_t chip_update(input bti_flags_t f,
                                             input logic signed [TEMP_W-1:0] die,
                                             input logic signed [TEMP_W-1:0] chip,
                                             input logic signed [TEMP_W-1:0] bank);
    bti_flags_t n;
    n.die_hot      = next_hot(f.die_hot, die, limits.die_disable, limits.die_enable);
    n.onboard_hot  = next_hot(f.onboard_hot, chip, limits.onboard_disable,
                              limits.onboard_enable);
    n.resistor_hot = next_hot(f.resistor_hot, bank, limits.resistor_disable,
                              limits.resistor_enable);
    return n;
  endfunction

  // one item: updates the segment's flags on a sample and returns the result
  function automatic bti_result_t interlock_step(input logic cmd_bit,
                                                 input logic [IN_DATA_W-1:0] d);
    bti_result_t r;
    bti_flags_t a, b, a_old, b_old, sel;
    logic [SEG_W-1:0] seg;
    logic signed [TEMP_W-1:0] ca, cb, chip_t;
    int idx;
    r = '0;
    seg = d[3:0];
    if (seg >= SEGMENT_COUNT) return r;
    idx = 2 * int'(seg);
    a_old = chip_flags[idx];
    b_old = chip_flags[idx+1];
    a = a_old;
    b = b_old;
    if (bti_cmd_e'(cmd_bit) == CMD_SAMPLE) begin
      ca = d[51:36];
      cb = d[67:52];
      chip_t = (cb > ca) ? cb : ca;
      a = chip_update(a_old, d[19:4], chip_t, d[83:68]);
      b = chip_update(b_old, d[35:20], chip_t, d[99:84]);
      chip_flags[idx]   = a;
      chip_flags[idx+1] = b;
      r.blocked_changed = ((|a_old) != (|a)) || ((|b_old) != (|b));
    end else begin
      sel = d[100] ? b : a;
      r.granted_duty = (|sel) ? '0 : d[104:101];
    end
    r.alpha         = a;
    r.beta          = b;
    r.alpha_blocked = |a;
    r.beta_blocked  = |b;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // watch config, both channels; results are retired before new items are queued
  always @(posedge clk_i or negedge rst_ni) begin
    bti_result_t exp_r, act_r;
    if (!rst_ni) begin
      limits.die_disable      = DIE_DISABLE_RST;
      limits.die_enable       = DIE_ENABLE_RST;
      limits.onboard_disable  = ONBOARD_DISABLE_RST;
      limits.onboard_enable   = ONBOARD_ENABLE_RST;
      limits.resistor_disable = RESISTOR_DISABLE_RST;
      limits.resistor_enable  = RESISTOR_ENABLE_RST;
      foreach (chip_flags[i]) chip_flags[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DIE_DISABLE:      limits.die_disable      = cfg_data_i;
          REG_DIE_ENABLE:       limits.die_enable       = cfg_data_i;
          REG_ONBOARD_DISABLE:  limits.onboard_disable  = cfg_data_i;
          REG_ONBOARD_ENABLE:   limits.onboard_enable   = cfg_data_i;
          REG_RESISTOR_DISABLE: limits.resistor_disable = cfg_data_i;
          REG_RESISTOR_ENABLE:  limits.resistor_enable  = cfg_data_i;
          default: ;
        endcase
      end
      // result transaction
      if (out_valid_i && out_ready_i) begin
        act_r = out_data_i[$bits(bti_result_t)-1:0];
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation: tdata %h", out_data_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          compare_field("alpha_die_hot", exp_r.alpha.die_hot, act_r.alpha.die_hot);
          compare_field("alpha_onboard_hot", exp_r.alpha.onboard_hot,
                        act_r.alpha.onboard_hot);
          compare_field("alpha_resistor_hot", exp_r.alpha.resistor_hot,
                        act_r.alpha.resistor_hot);
          compare_field("beta_die_hot", exp_r.beta.die_hot, act_r.beta.die_hot);
          compare_field("beta_onboard_hot", exp_r.beta.onboard_hot,
                        act_r.beta.onboard_hot);
          compare_field("beta_resistor_hot", exp_r.beta.resistor_hot,
                        act_r.beta.resistor_hot);
          compare_field("alpha_blocked", exp_r.alpha_blocked, act_r.alpha_blocked);
          compare_field("beta_blocked", exp_r.beta_blocked, act_r.beta_blocked);
          compare_field("blocked_changed", exp_r.blocked_changed, act_r.blocked_changed);
          compare_field("granted_duty", exp_r.granted_duty, act_r.granted_duty);
        end
      end
      // input transaction
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(interlock_step(in_user_i, in_data_i));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/tb.sv
module tb
  import bti_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [TEMP_W-1:0] T_MIN = 16'sh8000;
  localparam logic signed [TEMP_W-1:0] T_MAX = 16'sh7fff;
  localparam int PHASE_ITEMS    = 140;
  localparam int BURST_ITEMS    = 24;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int DRAIN_LIMIT    = 20000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [TEMP_W-1:0]     cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  bit          tx_gap_en   = 1'b1;
  bit          rx_stall_en = 1'b1;
  bit          rx_hold_req = 1'b0;
  bti_thresh_t cur_limits;

  balance_thermal_interlock_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bti_interlock_monitor flag_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // temperature near one of the pair's thresholds, sometimes anywhere or at an extreme
  function automatic logic [TEMP_W-1:0] pick_temp(input logic signed [TEMP_W-1:0] dis,
                                                  input logic signed [TEMP_W-1:0] en);
    int v;
    case ($urandom_range(0, 9))
      0: return TEMP_W'($urandom);
      1: return $urandom_range(0, 1) ? T_MAX : T_MIN;
      default: begin
        v = $urandom_range(0, 1) ? int'(dis) : int'(en);
        v = v + int'($urandom_range(0, 8)) - 4;
        if (v > int'(T_MAX)) v = int'(T_MAX);
        if (v < int'(T_MIN)) v = int'(T_MIN);
        return TEMP_W'(v);
      end
    endcase
  endfunction

  // disable/enable pair with disable at or above enable, around the normal range
  function automatic logic [2*TEMP_W-1:0] near_pair();
    int dis, en;
    dis = int'($urandom_range(0, 4000)) - 1000;
    en  = dis - int'($urandom_range(0, 400));
    return {TEMP_W'(dis), TEMP_W'(en)};
  endfunction

  // receiver: random stalls plus one long hold on request
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall = 1 + pick_gap();
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // offer one input transaction and hold it until accepted
  task automatic offer_item(input bti_cmd_e cmd, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = tx_gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_sample(input logic [SEG_W-1:0] seg,
                             input logic [TEMP_W-1:0] a_die, input logic [TEMP_W-1:0] b_die,
                             input logic [TEMP_W-1:0] a_chip, input logic [TEMP_W-1:0] b_chip,
                             input logic [TEMP_W-1:0] a_bank, input logic [TEMP_W-1:0] b_bank);
    logic [DUTY_W-1:0] junk_duty;
    logic              junk_side;
    junk_duty = $urandom_range(0, 15);
    junk_side = $urandom_range(0, 1);
    offer_item(CMD_SAMPLE, IN_DATA_W'({junk_duty, junk_side, b_bank, a_bank, b_chip, a_chip,
                                       b_die, a_die, seg}));
  endtask

  // thermal fields carry noise on a duty request
  task automatic send_duty(input logic [SEG_W-1:0] seg, input logic side,
                           input logic [DUTY_W-1:0] duty);
    offer_item(CMD_DUTY, IN_DATA_W'({duty, side, 96'({$urandom, $urandom, $urandom}),
                                     seg}));
  endtask

  task automatic random_item();
    logic [SEG_W-1:0] seg;
    seg = ($urandom_range(0, 9) == 0) ? SEG_W'($urandom_range(0, 15))
                                      : SEG_W'($urandom_range(0, SEGMENT_COUNT - 1));
    if ($urandom_range(0, 9) < 6) begin
      send_sample(seg,
                  pick_temp(cur_limits.die_disable, cur_limits.die_enable),
                  pick_temp(cur_limits.die_disable, cur_limits.die_enable),
                  pick_temp(cur_limits.onboard_disable, cur_limits.onboard_enable),
                  pick_temp(cur_limits.onboard_disable, cur_limits.onboard_enable),
                  pick_temp(cur_limits.resistor_disable, cur_limits.resistor_enable),
                  pick_temp(cur_limits.resistor_disable, cur_limits.resistor_enable));
    end else begin
      send_duty(seg, 1'($urandom_range(0, 1)), DUTY_W'($urandom_range(0, 15)));
    end
  endtask

  // sender pauses until every expected result has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // program all thresholds while idle, plus a write to a spare index
  task automatic set_limits(input bti_thresh_t t);
    wait_idle();
    repeat (3) @(posedge clk_i);
    write_reg(REG_DIE_DISABLE, t.die_disable);
    write_reg(REG_DIE_ENABLE, t.die_enable);
    write_reg(REG_ONBOARD_DISABLE, t.onboard_disable);
    write_reg(REG_ONBOARD_ENABLE, t.onboard_enable);
    write_reg(REG_RESISTOR_DISABLE, t.resistor_disable);
    write_reg(REG_RESISTOR_ENABLE, t.resistor_enable);
    write_reg(CFG_IDX_W'(REG_RESISTOR_ENABLE + $urandom_range(1, 2)), TEMP_W'($urandom));
    cfg_we_i <= 1'b0;
    cur_limits = t;
  endtask

  // stimulus and verdict
  initial begin
    bti_thresh_t t;
    int guard;
    cur_limits.die_disable      = DIE_DISABLE_RST;
    cur_limits.die_enable       = DIE_ENABLE_RST;
    cur_limits.onboard_disable  = ONBOARD_DISABLE_RST;
    cur_limits.onboard_enable   = ONBOARD_ENABLE_RST;
    cur_limits.resistor_disable = RESISTOR_DISABLE_RST;
    cur_limits.resistor_enable  = RESISTOR_ENABLE_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, exact thresholds, chip thermistor max, blocked duty, out-of-range segments
    send_sample(0, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN);
    send_duty(0, 1'b0, 4'd15);
    send_sample(0, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
    send_duty(0, 1'b1, 4'd9);
    send_duty(0, 1'b0, 4'd15);
    send_sample(0, 16'sd1201, 16'sd1201, 16'sd961, 16'sd961, 16'sd1441, 16'sd1441);
    send_sample(0, 16'sd1200, 16'sd1200, 16'sd960, 16'sd960, 16'sd1440, 16'sd1440);
    send_duty(0, 1'b1, 4'd6);
    send_sample(1, 16'sd1359, 16'sd1359, 16'sd1119, 16'sd1119, 16'sd1599, 16'sd1599);
    send_sample(1, 16'sd1360, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1600);
    send_duty(1, 1'b0, 4'd3);
    send_duty(1, 1'b1, 4'd3);
    send_sample(2, 16'sd0, 16'sd0, -16'sd5000, 16'sd1120, 16'sd0, 16'sd0);
    send_sample(3, 16'sd0, 16'sd0, 16'sd1120, T_MIN, 16'sd0, 16'sd0);
    send_duty(3, 1'b1, 4'd0);
    send_sample(4, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100);
    send_duty(4, 1'b1, 4'd15);
    send_sample(5, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
    send_sample(15, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
    send_duty(15, 1'b0, 4'd12);
    send_duty(5, 1'b1, 4'd7);

    // long receiver hold with back-to-back items, then drain
    tx_gap_en = 1'b0;
    rx_hold_req = 1'b1;
    repeat (BURST_ITEMS) random_item();
    wait_idle();

    // threshold settings, extremes included, with varied idling
    for (int p = 0; p < 6; p++) begin
      t = cur_limits;
      case (p)
        1: begin
          t.die_disable      = T_MIN;
          t.die_enable       = T_MAX;
          t.onboard_disable  = T_MIN;
          t.onboard_enable   = T_MAX;
          t.resistor_disable = T_MIN;
          t.resistor_enable  = T_MAX;
        end
        2: begin
          t.die_disable      = T_MAX;
          t.die_enable       = T_MIN;
          t.onboard_disable  = T_MAX;
          t.onboard_enable   = T_MIN;
          t.resistor_disable = T_MAX;
          t.resistor_enable  = T_MIN;
        end
        3: begin
          {t.die_disable, t.die_enable}           = near_pair();
          {t.onboard_disable, t.onboard_enable}   = near_pair();
          {t.resistor_disable, t.resistor_enable} = near_pair();
        end
        4: t = bti_thresh_t'({$urandom, $urandom, $urandom});
        5: begin
          t.die_disable      = DIE_DISABLE_RST;
          t.die_enable       = DIE_ENABLE_RST;
          t.onboard_disable  = ONBOARD_DISABLE_RST;
          t.onboard_enable   = ONBOARD_ENABLE_RST;
          t.resistor_disable = RESISTOR_DISABLE_RST;
          t.resistor_enable  = RESISTOR_ENABLE_RST;
        end
        default: ;
      endcase
      if (p != 0) set_limits(t);
      tx_gap_en   = (p % 3) != 2;
      rx_stall_en = (p % 3) != 1;
      repeat (PHASE_ITEMS) random_item();
    end

    // drain and settle
    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bti_pkg.sv
rtl/core/bti_lane.sv
rtl/core/bti_merge.sv
rtl/core/balance_thermal_interlock_top.sv
tb/bti_interlock_monitor.sv
tb/tb.sv
